FILE: sv/swlru_pkg.sv
`timescale 1ns / 1ps
// Package for the size-weighted LRU residency unit: widths, word types,
// event codes, controller states and the ring address helper. No dependencies.
package swlru_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ID_W        = 16;
  localparam int unsigned SIZE_W      = 20;
  localparam int unsigned LIMIT_W     = 24;
  localparam int unsigned TOTAL_W     = LIMIT_W + 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd4096;

  localparam logic ACT_ACCESS  = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    EV_EVICT = 2'd0,
    EV_LOAD  = 2'd1,
    EV_HIT   = 2'd2,
    EV_FREED = 2'd3
  } ev_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_COPY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   item_id;
    logic [SIZE_W-1:0] item_size;
  } in_word_t;

  typedef struct packed {
    ev_kind_e        event_kind;
    logic [ID_W-1:0] event_id;
    logic            last;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Physical slot of a list position, with the list stored as a ring.
  function automatic idx_t phys_addr(idx_t base, idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: sv/size_weighted_lru_residency_unit.sv
`timescale 1ns / 1ps
// Size-weighted LRU residency unit: list memory, walk and compaction controller.
// Depends on swlru_pkg.
//
// This block tracks up to swlru_pkg::QUEUE_DEPTH resident items, most recent
// first, each with an id and a size in MiB. An access word walks the list from
// the front, evicts every entry that would push the running total over
// memory_limit, stops at a matching id, and puts the item at the front,
// reporting hit or load; a release word removes the item if present and
// reports freed. Every input word produces one or more output words, and the
// final one carries last. One word is processed at a time. The list memory is
// read one entry per cycle during the walk and the tail copy, except while an
// eviction waits on a stalled output. There is no clearing pass after reset.
module size_weighted_lru_residency_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  swlru_pkg::in_word_t         in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output swlru_pkg::out_word_t        out_word_o,
  input  logic                        cfg_we_i,
  input  logic [swlru_pkg::LIMIT_W-1:0] cfg_wdata_i
);

  // The list lives in a ring: position p sits in slot (base + p) mod depth.
  // Putting an item at the front moves base back by one, so compaction only
  // ever writes slots the walk has already read.
  swlru_pkg::entry_t mem_q [swlru_pkg::QUEUE_DEPTH];
  swlru_pkg::entry_t rdata_q;

  swlru_pkg::state_e state_q, state_d;
  swlru_pkg::in_word_t item_q, item_d;
  logic [swlru_pkg::TOTAL_W-1:0] total_q, total_d;
  logic [swlru_pkg::LIMIT_W-1:0] limit_q;
  swlru_pkg::idx_t s_q, s_d;       // position of the entry in rdata_q
  swlru_pkg::idx_t w_q, w_d;       // old entries kept so far, and next write slot
  swlru_pkg::idx_t base_q, base_d;
  swlru_pkg::cnt_t cnt_q, cnt_d;
  logic hit_q, hit_d;

  logic out_valid_q;
  swlru_pkg::out_word_t out_word_q;

  logic rd_en, mem_we, emit, emit_ok, go;
  swlru_pkg::idx_t rd_addr, wr_addr, new_base, s_inc_idx;
  swlru_pkg::entry_t wr_data;
  swlru_pkg::out_word_t emit_word;
  swlru_pkg::cnt_t s_inc;
  logic [swlru_pkg::TOTAL_W-1:0] sum_total;
  logic more, match, over, w_is_top, is_rel, in_accept;

  assign in_stall_o  = (state_q != swlru_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // A new output word may be loaded when the output register is empty or
  // is being taken in this cycle.
  assign emit_ok = !out_valid_q || !out_stall_i;

  assign s_inc     = swlru_pkg::CNT_W'(s_q) + swlru_pkg::CNT_W'(1);
  assign s_inc_idx = s_q + swlru_pkg::idx_t'(1);
  assign more      = (s_inc < cnt_q);
  assign match     = (rdata_q.id == item_q.item_id);
  assign sum_total = total_q + swlru_pkg::TOTAL_W'(rdata_q.size);
  assign over      = (sum_total > swlru_pkg::TOTAL_W'(limit_q));
  // A kept entry that would make the new list one too long is the oldest one
  // left and is evicted instead.
  assign w_is_top  = (w_q == swlru_pkg::idx_t'(swlru_pkg::QUEUE_DEPTH - 1));
  assign is_rel    = (item_q.action == swlru_pkg::ACT_RELEASE);
  assign new_base  = (base_q == '0) ? swlru_pkg::idx_t'(swlru_pkg::QUEUE_DEPTH - 1)
                                    : base_q - swlru_pkg::idx_t'(1);

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    total_d = total_q;
    s_d     = s_q;
    w_d     = w_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    hit_d   = hit_q;
    go      = 1'b0;
    rd_en   = 1'b0;
    rd_addr = swlru_pkg::phys_addr(base_q, s_inc_idx);
    mem_we  = 1'b0;
    wr_addr = swlru_pkg::phys_addr(base_q, w_q);
    wr_data = rdata_q;
    emit    = 1'b0;
    emit_word.event_kind = swlru_pkg::EV_EVICT;
    emit_word.event_id   = rdata_q.id;
    emit_word.last       = 1'b0;

    case (state_q)
      swlru_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_word_i;
          total_d = swlru_pkg::TOTAL_W'(in_word_i.item_size);
          s_d     = '0;
          w_d     = '0;
          hit_d   = 1'b0;
          if (cnt_q == '0) begin
            state_d = swlru_pkg::ST_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = base_q;
            state_d = swlru_pkg::ST_WALK;
          end
        end
      end

      swlru_pkg::ST_WALK: begin
        go = 1'b1;
        if (match) begin
          hit_d = 1'b1;
          if (is_rel) begin
            w_d = s_q;
          end
        end else if (!is_rel) begin
          if (over || w_is_top) begin
            go   = emit_ok;
            emit = emit_ok;
          end else begin
            mem_we  = 1'b1;
            w_d     = w_q + swlru_pkg::idx_t'(1);
            total_d = sum_total;
          end
        end
        if (go) begin
          if (more) begin
            rd_en = 1'b1;
            s_d   = s_inc_idx;
            if (match) begin
              state_d = swlru_pkg::ST_COPY;
            end
          end else begin
            state_d = swlru_pkg::ST_DONE;
          end
        end
      end

      swlru_pkg::ST_COPY: begin
        // Entries older than the match close the gap left behind.
        mem_we = 1'b1;
        w_d    = w_q + swlru_pkg::idx_t'(1);
        if (more) begin
          rd_en = 1'b1;
          s_d   = s_inc_idx;
        end else begin
          state_d = swlru_pkg::ST_DONE;
        end
      end

      swlru_pkg::ST_DONE: begin
        emit_word.event_id = item_q.item_id;
        emit_word.last     = 1'b1;
        if (is_rel) begin
          emit_word.event_kind = swlru_pkg::EV_FREED;
        end else if (hit_q) begin
          emit_word.event_kind = swlru_pkg::EV_HIT;
        end else begin
          emit_word.event_kind = swlru_pkg::EV_LOAD;
        end
        wr_addr         = new_base;
        wr_data.id      = item_q.item_id;
        wr_data.size    = item_q.item_size;
        if (emit_ok) begin
          emit    = 1'b1;
          state_d = swlru_pkg::ST_IDLE;
          if (is_rel) begin
            if (hit_q) begin
              cnt_d = cnt_q - swlru_pkg::cnt_t'(1);
            end
          end else begin
            mem_we = 1'b1;
            base_d = new_base;
            cnt_d  = swlru_pkg::CNT_W'(w_q) + swlru_pkg::CNT_W'(1);
          end
        end
      end

      default: begin
        state_d = swlru_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swlru_pkg::ST_IDLE;
      base_q      <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      limit_q     <= swlru_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    total_q <= total_d;
    s_q     <= s_d;
    w_q     <= w_d;
    if (emit) begin
      out_word_q <= emit_word;
    end
  end

  // List memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= swlru_pkg::CNT_W'(swlru_pkg::QUEUE_DEPTH))
    else $error("entry count exceeds list depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && rd_en) |-> (wr_addr != rd_addr))
    else $error("compaction write hits the slot being read");

  a_write_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swlru_pkg::ST_WALK) |-> (w_q <= s_q))
    else $error("write position passed read position");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swlru_pkg::ST_DONE && state_d == swlru_pkg::ST_IDLE)
      |=> (out_valid_q && out_word_q.last))
    else $error("final word not marked last");

  a_clean_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> !(out_valid_q && !out_word_q.last))
    else $error("new word accepted while earlier results are pending");

endmodule
